// File: sv/cihm_pkg.sv
// Shared types, codes and sizes for the context id / handle map.
// No dependencies; used by the top level, the port checker and the testbench.

package cihm_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int OP_W     = 2;
    localparam int ID_W     = 32;
    localparam int HANDLE_W = 64;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_ADD         = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND_HANDLE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND_ID     = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP         = 2'd3;

    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_ABSENT       = 3'd1;
    localparam logic [ST_W-1:0] ST_CHANGED      = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN_FULL = 3'd4;

endpackage

// File: sv/cihm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module cihm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/context_id_handle_map.sv
// Top level of the context id / handle map: sequencer and compare unit.
// Depends on cihm_pkg and cihm_ram.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one word: operation,
//   context_id, context_handle. Response channel (rsp_valid/rsp_ready)
//   returns one word per request: status, found_id, found_handle.
//   Operations: add pair, find handle by id, find id by handle.
//   Each request scans the filled slots in order through one RAM read port
//   and one shared comparator, one slot per cycle, with the compare in the
//   cycle after the read. A hit ends the scan at that slot; a miss scans
//   every filled slot. The unused opcode skips the scan.
//   One request is in flight at a time: req_ready is low from acceptance
//   until the response word is taken, so a new request is taken only after
//   the response word of the one before it is taken.
//   While the receiver stalls, the response word is held stable and no
//   new request is taken.
//   Reset empties the table at once through the fill count; RAM contents
//   beyond the fill count are never used, so no clearing pass is needed.

module context_id_handle_map #(
    parameter int TABLE_ENTRIES = cihm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [cihm_pkg::OP_W-1:0]     operation,
    input  logic [cihm_pkg::ID_W-1:0]     context_id,
    input  logic [cihm_pkg::HANDLE_W-1:0] context_handle,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [cihm_pkg::ST_W-1:0]     status,
    output logic [cihm_pkg::ID_W-1:0]     found_id,
    output logic [cihm_pkg::HANDLE_W-1:0] found_handle
);

    import cihm_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = ID_W + HANDLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    fill_reg,       fill_next;
    logic [CNT_W-1:0]    n_reg,          n_next;
    logic [CNT_W-1:0]    rd_idx_reg,     rd_idx_next;
    logic [CNT_W-1:0]    chk_idx_reg,    chk_idx_next;
    logic                pend_reg,       pend_next;
    logic [OP_W-1:0]     op_reg,         op_next;
    logic [ID_W-1:0]     key_id_reg,     key_id_next;
    logic [HANDLE_W-1:0] key_handle_reg, key_handle_next;
    logic [ST_W-1:0]     status_reg,     status_next;
    logic [ID_W-1:0]     res_id_reg,     res_id_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;

    logic                wr_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ID_W-1:0]     rd_id;
    logic [HANDLE_W-1:0] rd_handle;
    logic                table_full;
    logic                hit_now;
    logic                last_now;

    cihm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(n_reg[IDX_W-1:0]),
        .wr_data({key_id_reg, key_handle_reg}),
        .rd_addr(rd_idx_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    assign rd_id     = rd_data[ENTRY_W-1:HANDLE_W];
    assign rd_handle = rd_data[HANDLE_W-1:0];

    assign table_full = (n_reg == CNT_W'(TABLE_ENTRIES));
    assign hit_now    = pend_reg && ((op_reg == OP_FIND_ID) ? (rd_handle == key_handle_reg)
                                                            : (rd_id == key_id_reg));
    assign last_now   = pend_reg && (CNT_W'(chk_idx_reg + 1'b1) == n_reg);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        key_id_next     = key_id_reg;
        key_handle_next = key_handle_reg;
        status_next     = status_reg;
        res_id_next     = res_id_reg;
        res_handle_next = res_handle_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = operation;
                    key_id_next     = context_id;
                    key_handle_next = context_handle;
                    n_next          = fill_reg;
                    rd_idx_next     = '0;
                    chk_idx_next    = '0;
                    pend_next       = 1'b0;
                    status_next     = ST_OK;
                    res_id_next     = '0;
                    res_handle_next = '0;
                    state_next      = (operation == OP_NOP) ? S_DONE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // advance the read one slot ahead of the compare
                if (rd_idx_reg < n_reg)
                begin
                    rd_idx_next  = CNT_W'(rd_idx_reg + 1'b1);
                    chk_idx_next = rd_idx_reg;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (hit_now)
                begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            status_next = (rd_handle != key_handle_reg) ? ST_CHANGED : ST_OK;
                        end
                        OP_FIND_HANDLE: res_handle_next = rd_handle;
                        OP_FIND_ID:     res_id_next     = rd_id;
                        default:        status_next     = ST_OK;
                    endcase
                end
                else if ((n_reg == '0) || last_now)
                begin
                    state_next = S_DONE;
                    unique case (op_reg) inside
                        OP_ADD:
                        begin
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                if (key_handle_reg != '0)
                                begin
                                    wr_en     = 1'b1;
                                    fill_next = CNT_W'(fill_reg + 1'b1);
                                end
                            end
                        end
                        OP_FIND_HANDLE, OP_FIND_ID:
                        begin
                            status_next = table_full ? ST_UNKNOWN_FULL : ST_ABSENT;
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end

            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            n_reg          <= '0;
            rd_idx_reg     <= '0;
            chk_idx_reg    <= '0;
            pend_reg       <= 1'b0;
            op_reg         <= OP_NOP;
            key_id_reg     <= '0;
            key_handle_reg <= '0;
            status_reg     <= ST_OK;
            res_id_reg     <= '0;
            res_handle_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            n_reg          <= n_next;
            rd_idx_reg     <= rd_idx_next;
            chk_idx_reg    <= chk_idx_next;
            pend_reg       <= pend_next;
            op_reg         <= op_next;
            key_id_reg     <= key_id_next;
            key_handle_reg <= key_handle_next;
            status_reg     <= status_next;
            res_id_reg     <= res_id_next;
            res_handle_reg <= res_handle_next;
        end
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = (state_reg == S_DONE);
    assign status       = status_reg;
    assign found_id     = res_id_reg;
    assign found_handle = res_handle_reg;

endmodule

// File: sv/cihm_checker.sv
// Port-level checks for the context id / handle map, bound to the top level.
// Depends on cihm_pkg and context_id_handle_map.

module cihm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [cihm_pkg::OP_W-1:0]     operation,
    input logic [cihm_pkg::ID_W-1:0]     context_id,
    input logic [cihm_pkg::HANDLE_W-1:0] context_handle,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [cihm_pkg::ST_W-1:0]     status,
    input logic [cihm_pkg::ID_W-1:0]     found_id,
    input logic [cihm_pkg::HANDLE_W-1:0] found_handle
);

    import cihm_pkg::*;

    // one word in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a word is in flight");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("ready for a request while a response waits");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)))
        else $error("response dropped or changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_UNKNOWN_FULL))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_OK)) |-> ((found_id == '0) && (found_handle == '0)))
        else $error("nonzero result on a failing status");

endmodule

bind context_id_handle_map cihm_checker u_cihm_checker (.*);

// File: tb/sv/cihm_map_checker.sv
`timescale 1ns / 100ps
// Checker for context_id_handle_map: mirrors the id/handle table and predicts each response word.
// Compares responses in order with the predictions and tallies statuses. Depends on cihm_pkg.

module cihm_map_checker #(
    parameter int ENTRIES = cihm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic [cihm_pkg::OP_W-1:0]     operation,
    input  logic [cihm_pkg::ID_W-1:0]     context_id,
    input  logic [cihm_pkg::HANDLE_W-1:0] context_handle,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [cihm_pkg::ST_W-1:0]     status,
    input  logic [cihm_pkg::ID_W-1:0]     found_id,
    input  logic [cihm_pkg::HANDLE_W-1:0] found_handle,
    output int                            mismatches,
    output int                            awaited,
    output int                            status_tally [5]
);

    import cihm_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } map_reply_t;

    logic [ID_W-1:0]     slot_id     [ENTRIES];
    logic [HANDLE_W-1:0] slot_handle [ENTRIES];
    int                  slots_live;
    map_reply_t          reply_queue [$];

    function automatic map_reply_t lookup_or_add(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] key_id,
                                                 input logic [HANDLE_W-1:0] key_handle);
        map_reply_t r;
        logic       hit;
        logic [ST_W-1:0] miss_code;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        miss_code = (slots_live >= ENTRIES) ? ST_UNKNOWN_FULL : ST_ABSENT;
        case (op)
            OP_ADD:
            begin
                for (int i = 0; i < slots_live && !hit; i++)
                begin
                    if (slot_id[i] == key_id)
                    begin
                        hit = 1'b1;
                        if (slot_handle[i] != key_handle)
                            r.status = ST_CHANGED;
                    end
                end
                if (!hit)
                begin
                    if (slots_live >= ENTRIES)
                        r.status = ST_FULL;
                    else if (key_handle != '0)
                    begin
                        slot_id[slots_live] = key_id;
                        slot_handle[slots_live] = key_handle;
                        slots_live++;
                    end
                end
            end
            OP_FIND_HANDLE:
            begin
                for (int i = 0; i < slots_live && !hit; i++)
                begin
                    if (slot_id[i] == key_id)
                    begin
                        hit = 1'b1;
                        r.handle = slot_handle[i];
                    end
                end
                if (!hit)
                    r.status = miss_code;
            end
            OP_FIND_ID:
            begin
                for (int i = 0; i < slots_live && !hit; i++)
                begin
                    if (slot_handle[i] == key_handle)
                    begin
                        hit = 1'b1;
                        r.id = slot_id[i];
                    end
                end
                if (!hit)
                    r.status = miss_code;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t want;
        if (!rst_n)
        begin
            slots_live = 0;
            reply_queue.delete();
            awaited = 0;
            mismatches = 0;
            foreach (status_tally[s])
                status_tally[s] = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (reply_queue.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (found_id !== want.id)
                    begin
                        $error("found_id: expected %h, got %h", want.id, found_id);
                        mismatches++;
                    end
                    if (found_handle !== want.handle)
                    begin
                        $error("found_handle: expected %h, got %h", want.handle, found_handle);
                        mismatches++;
                    end
                    if (want.status <= ST_UNKNOWN_FULL)
                        status_tally[want.status]++;
                end
            end
            if (req_valid && req_ready)
                reply_queue.push_back(lookup_or_add(operation, context_id, context_handle));
            awaited = reply_queue.size();
        end
    end

endmodule

// File: tb/sv/tb_context_id_handle_map.sv
`timescale 1ns / 100ps
// Testbench top for context_id_handle_map: clock, reset, request stimulus and response stalls.
// Depends on cihm_pkg, context_id_handle_map and cihm_map_checker.

module tb_context_id_handle_map;
    import cihm_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     context_id;
    logic [HANDLE_W-1:0] context_handle;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [ST_W-1:0]     status;
    logic [ID_W-1:0]     found_id;
    logic [HANDLE_W-1:0] found_handle;

    int mismatches;
    int awaited;
    int status_tally [5];

    int idle_pct;
    int stall_pct;
    int words_sent;

    logic [ID_W-1:0]     known_ids     [$];
    logic [HANDLE_W-1:0] known_handles [$];

    context_id_handle_map dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .operation      (operation),
        .context_id     (context_id),
        .context_handle (context_handle),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .found_id       (found_id),
        .found_handle   (found_handle)
    );

    cihm_map_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .operation      (operation),
        .context_id     (context_id),
        .context_handle (context_handle),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .found_id       (found_id),
        .found_handle   (found_handle),
        .mismatches     (mismatches),
        .awaited        (awaited),
        .status_tally   (status_tally)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        rsp_ready = 1'b0;
        operation = OP_NOP;
        context_id = '0;
        context_handle = '0;
        idle_pct = 0;
        stall_pct = 0;
        words_sent = 0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [HANDLE_W-1:0] hdl);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        context_id <= id;
        context_handle <= hdl;
        do
            @(posedge clk);
        while (!req_ready);
        words_sent++;
        if (op == OP_ADD && hdl != '0)
        begin
            known_ids.push_back(id);
            known_handles.push_back(hdl);
            if (known_ids.size() > 64)
            begin
                void'(known_ids.pop_front());
                void'(known_handles.pop_front());
            end
        end
    endtask

    task automatic drain_replies();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    task automatic random_word();
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] hdl;
        int                  pick;
        int                  r;
        r = $urandom_range(0, 99);
        op = (r < 35) ? OP_ADD : (r < 62) ? OP_FIND_HANDLE : (r < 94) ? OP_FIND_ID : OP_NOP;
        pick = (known_ids.size() > 0) ? $urandom_range(0, known_ids.size() - 1) : -1;
        r = $urandom_range(0, 99);
        if (pick >= 0 && r < 50)
            id = known_ids[pick];
        else if (r < 70)
            id = $urandom_range(0, 15);
        else
            id = $urandom;
        r = $urandom_range(0, 99);
        if (pick >= 0 && r < 50)
            hdl = known_handles[pick];
        else if (r < 60)
            hdl = '0;
        else if (r < 70)
            hdl = HANDLE_W'($urandom_range(1, 15));
        else
            hdl = {$urandom, $urandom};
        send_word(op, id, hdl);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) random_word();
        drain_replies();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused opcode, zero handle adds, duplicates and collisions
        send_word(OP_FIND_HANDLE, '0, '0);
        send_word(OP_FIND_ID, '1, '0);
        send_word(OP_NOP, '1, '1);
        send_word(OP_ADD, '0, '0);
        send_word(OP_FIND_HANDLE, '0, '0);
        send_word(OP_ADD, '0, '1);
        send_word(OP_ADD, '0, '1);
        send_word(OP_ADD, '0, 64'h1);
        send_word(OP_ADD, '0, '0);
        send_word(OP_ADD, '1, 64'h1);
        send_word(OP_ADD, 32'h5, 64'h1);
        send_word(OP_FIND_ID, '0, 64'h1);
        send_word(OP_FIND_HANDLE, '1, '0);
        send_word(OP_FIND_HANDLE, 32'h5, '1);
        send_word(OP_FIND_ID, 32'h5, '1);
        send_word(OP_FIND_ID, '0, '0);
        send_word(OP_ADD, 32'h7, '0);
        send_word(OP_FIND_HANDLE, 32'h7, '0);
        send_word(OP_ADD, 32'hA5A5_5A5A, 64'h5A5A_A5A5_F00F_0FF0);
        send_word(OP_FIND_ID, '0, 64'h5A5A_A5A5_F00F_0FF0);
        send_word(OP_NOP, '0, '0);
        drain_replies();

        run_phase(0, 0, 300);
        run_phase(69, 0, 300);
        run_phase(0, 69, 300);
        run_phase(6, 6, 300);

        repeat (40) @(posedge clk);
        $display("Sent %0d request words through no-idle, sender-idle, receiver-stall and mixed runs.",
                 words_sent);
        $display("Responses: ok %0d, absent %0d, changed %0d, full %0d, unknown key in full %0d.",
                 status_tally[ST_OK], status_tally[ST_ABSENT], status_tally[ST_CHANGED],
                 status_tally[ST_FULL], status_tally[ST_UNKNOWN_FULL]);
        if (mismatches == 0 && awaited == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
